// File: sv/rrw_pkg.sv
package rrw_pkg;

    typedef logic [18:0] dx_t;
    typedef logic [17:0] dy_t;
    typedef logic [39:0] rad_t;
    typedef logic [19:0] root_t;
    typedef logic [22:0] rem_t;
    typedef logic [15:0] num_t;
    typedef logic [20:0] drem_t;
    typedef logic [15:0] quo_t;
    typedef logic [11:0] addr_t;
    typedef logic [7:0]  byte_t;
    typedef logic [1:0]  cfg_idx_t;

    localparam int SQ_STEPS  = 20;
    localparam int DIV_STEPS = 16;

    localparam cfg_idx_t CFG_FREQUENCY = 2'd0;
    localparam cfg_idx_t CFG_AMPLITUDE = 2'd1;
    localparam cfg_idx_t CFG_PHASE     = 2'd2;

    localparam logic [15:0] FREQ_RESET  = 16'd4096;
    localparam logic [15:0] AMP_RESET   = 16'd16384;
    localparam logic [15:0] PHASE_RESET = 16'd5215;

    // round(2^24 / (2*pi))
    localparam logic [21:0] INV_TWO_PI = 22'd2670177;
    localparam logic [15:0] SIN_A      = 16'd51472;
    localparam logic [14:0] SIN_B      = 15'd21024;
    localparam logic [11:0] SIN_C      = 12'd2320;
    localparam logic [14:0] QUARTER    = 15'd16384;
    localparam byte_t       BYTE_MID   = 8'd128;

    // square root cell payload
    typedef struct packed {
        rad_t  rad;
        rem_t  rem;
        root_t root;
        dx_t   dx;
        dy_t   dy;
        addr_t addr;
    } sq_t;

    // divider cell payload, x and y lanes share the divisor
    typedef struct packed {
        root_t d;
        num_t  numx;
        drem_t remx;
        quo_t  qx;
        num_t  numy;
        drem_t remy;
        quo_t  qy;
        addr_t addr;
    } dv_t;

endpackage

// File: sv/rrw_sqrt_cell.sv
module rrw_sqrt_cell (
    input  logic           clk,
    input  logic           en,
    input  rrw_pkg::sq_t   d_in,
    output rrw_pkg::sq_t   d_out
);

    rrw_pkg::sq_t  d_reg;
    rrw_pkg::sq_t  d_next;
    rrw_pkg::rem_t cur;
    rrw_pkg::rem_t trial;

    always_comb
    begin
        d_next = d_in;
        cur    = {d_in.rem[20:0], d_in.rad[39:38]};
        trial  = {1'b0, d_in.root, 2'b01};
        d_next.rad = {d_in.rad[37:0], 2'b00};
        if (cur >= trial)
        begin
            d_next.rem  = cur - trial;
            d_next.root = {d_in.root[18:0], 1'b1};
        end
        else
        begin
            d_next.rem  = cur;
            d_next.root = {d_in.root[18:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// File: sv/rrw_div_cell.sv
module rrw_div_cell (
    input  logic           clk,
    input  logic           en,
    input  rrw_pkg::dv_t   d_in,
    output rrw_pkg::dv_t   d_out
);

    rrw_pkg::dv_t  d_reg;
    rrw_pkg::dv_t  d_next;
    rrw_pkg::drem_t curx;
    rrw_pkg::drem_t cury;
    rrw_pkg::drem_t dvs;

    always_comb
    begin
        d_next = d_in;
        dvs    = {1'b0, d_in.d};
        curx   = {d_in.remx[19:0], d_in.numx[15]};
        cury   = {d_in.remy[19:0], d_in.numy[15]};
        d_next.numx = {d_in.numx[14:0], 1'b0};
        d_next.numy = {d_in.numy[14:0], 1'b0};
        if (curx >= dvs)
        begin
            d_next.remx = curx - dvs;
            d_next.qx   = {d_in.qx[14:0], 1'b1};
        end
        else
        begin
            d_next.remx = curx;
            d_next.qx   = {d_in.qx[14:0], 1'b0};
        end
        if (cury >= dvs)
        begin
            d_next.remy = cury - dvs;
            d_next.qy   = {d_in.qy[14:0], 1'b1};
        end
        else
        begin
            d_next.remy = cury;
            d_next.qy   = {d_in.qy[14:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// File: sv/rrw_back.sv
module rrw_back (
    input  logic            clk,
    input  logic            en,
    input  rrw_pkg::root_t  d,
    input  rrw_pkg::quo_t   ux,
    input  rrw_pkg::quo_t   uy,
    input  rrw_pkg::addr_t  addr,
    input  logic [15:0]     frequency,
    input  logic [15:0]     amplitude,
    input  logic [15:0]     phase_angle,
    output rrw_pkg::addr_t  addr_out,
    output rrw_pkg::byte_t  bx,
    output rrw_pkg::byte_t  by
);

    localparam int NST = 10;

    // sideband carried along every stage
    rrw_pkg::addr_t addr_reg [NST];
    rrw_pkg::quo_t  ux_reg   [NST];
    rrw_pkg::quo_t  uy_reg   [NST];
    logic           dz_reg   [NST];

    logic [35:0] prod_reg;
    logic [39:0] hik_reg;
    logic [39:0] lok_reg;
    logic [15:0] ang_reg;
    logic [29:0] zz_reg;
    logic [14:0] z_reg   [3:5];
    logic        neg_reg [3:8];
    logic [14:0] z2_reg  [4:5];
    logic [26:0] t_reg;
    logic [29:0] m_reg;
    logic [30:0] zp_reg;
    logic [32:0] usx_reg;
    logic [32:0] usy_reg;
    logic [48:0] usax_reg;
    logic [48:0] usay_reg;
    rrw_pkg::byte_t bx_reg;
    rrw_pkg::byte_t by_reg;

    logic [57:0] ang_full;
    logic [14:0] z_next;
    logic [14:0] inner;
    logic [15:0] p_val;
    logic [16:0] s_val;
    rrw_pkg::byte_t bx_next;
    rrw_pkg::byte_t by_next;

    function automatic rrw_pkg::byte_t to_byte(input logic [48:0] usa, input logic neg);
        logic [55:0] mag;
        logic [56:0] total;
        begin
            mag = {usa, 7'b0} - {7'b0, usa};
            if (neg)
            begin
                if (mag > (56'd1 << 51))
                begin
                    to_byte = 8'd0;
                end
                else
                begin
                    total   = (57'd1 << 51) - {1'b0, mag};
                    to_byte = total[51:44];
                end
            end
            else
            begin
                total = (57'd1 << 51) + {1'b0, mag};
                if (total[56:52] != 5'd0)
                begin
                    to_byte = 8'd255;
                end
                else
                begin
                    to_byte = total[51:44];
                end
            end
        end
    endfunction

    always_comb
    begin
        ang_full = {hik_reg, 18'b0} + {18'b0, lok_reg};
        z_next   = ang_reg[14] ? (rrw_pkg::QUARTER - {1'b0, ang_reg[13:0]})
                               : {1'b0, ang_reg[13:0]};
        inner    = rrw_pkg::SIN_B - {2'b0, t_reg[26:14]};
        p_val    = rrw_pkg::SIN_A - m_reg[29:14];
        s_val    = zp_reg[30:14];
        bx_next  = dz_reg[8] ? rrw_pkg::BYTE_MID : to_byte(usax_reg, neg_reg[8]);
        by_next  = dz_reg[8] ? rrw_pkg::BYTE_MID : to_byte(usay_reg, neg_reg[8]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            addr_reg[0] <= addr;
            ux_reg[0]   <= ux;
            uy_reg[0]   <= uy;
            dz_reg[0]   <= (d == '0);
            for (int i = 1; i < NST; i++)
            begin
                addr_reg[i] <= addr_reg[i-1];
                ux_reg[i]   <= ux_reg[i-1];
                uy_reg[i]   <= uy_reg[i-1];
                dz_reg[i]   <= dz_reg[i-1];
            end
            prod_reg <= 36'(d * frequency);
            hik_reg  <= 40'(prod_reg[35:18] * rrw_pkg::INV_TWO_PI);
            lok_reg  <= 40'(prod_reg[17:0] * rrw_pkg::INV_TWO_PI);
            ang_reg  <= ang_full[50:35] + phase_angle;
            zz_reg     <= 30'(z_next * z_next);
            z_reg[3]   <= z_next;
            neg_reg[3] <= ang_reg[15];
            for (int i = 4; i <= 5; i++)
            begin
                z_reg[i] <= z_reg[i-1];
            end
            for (int i = 4; i <= 8; i++)
            begin
                neg_reg[i] <= neg_reg[i-1];
            end
            z2_reg[4] <= zz_reg[28:14];
            t_reg     <= 27'(zz_reg[28:14] * rrw_pkg::SIN_C);
            z2_reg[5] <= z2_reg[4];
            m_reg     <= 30'(z2_reg[4] * inner);
            zp_reg    <= 31'(z_reg[5] * p_val);
            usx_reg   <= 33'(ux_reg[6] * s_val);
            usy_reg   <= 33'(uy_reg[6] * s_val);
            usax_reg  <= 49'(usx_reg * amplitude);
            usay_reg  <= 49'(usy_reg * amplitude);
            bx_reg    <= bx_next;
            by_reg    <= by_next;
        end
    end

    assign addr_out = addr_reg[NST-1];
    assign bx       = bx_reg;
    assign by       = by_reg;

endmodule

// File: sv/radial_ripple_warp_texel_gen.sv
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------------
// texel     | texel_valid / texel_ready  | texel_row, texel_col
// result    | result_valid / result_ready| byte_address, offset_x, offset_y
// config    | cfg_write (no wait)        | cfg_index, cfg_data
//
// one texel per cycle unless a held result stalls the pipeline; each texel passes
// through the 20 square root cells, 16 divider cells and the sine pipeline
// the whole pipeline advances as one; a held result stalls every stage
// reset clears the valid bits and loads the default ripple settings
module radial_ripple_warp_texel_gen #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                texel_valid,
    output logic                texel_ready,
    input  logic [4:0]          texel_row,
    input  logic [5:0]          texel_col,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [11:0]         byte_address,
    output logic [7:0]          offset_x,
    output logic [7:0]          offset_y,
    input  logic                cfg_write,
    input  rrw_pkg::cfg_idx_t   cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int TILES_PER_ROW = MAP_WIDTH / 4;
    localparam int SQ0 = 2;
    localparam int SQN = SQ0 + rrw_pkg::SQ_STEPS;
    localparam int DVN = SQN + rrw_pkg::DIV_STEPS;
    localparam int LAT = DVN + 11;

    logic [15:0] frequency_reg;
    logic [15:0] amplitude_reg;
    logic [15:0] phase_reg;

    logic [LAT-1:0] vld_reg;
    logic           adv;

    rrw_pkg::dx_t dx_lut [64];
    rrw_pkg::dy_t dy_lut [32];

    for (genvar g = 0; g < 64; g++)
    begin : g_dx
        localparam int DXV = (g * 32768) / MAP_WIDTH;
        assign dx_lut[g] = rrw_pkg::dx_t'(DXV);
    end

    for (genvar g = 0; g < 32; g++)
    begin : g_dy
        localparam int DYV = (g * 32768) / MAP_HEIGHT;
        assign dy_lut[g] = rrw_pkg::dy_t'(DYV);
    end

    rrw_pkg::dx_t   dx_reg [2];
    rrw_pkg::dy_t   dy_reg [2];
    rrw_pkg::addr_t addr_reg [2];
    logic [37:0]    sqx_reg;
    logic [35:0]    sqy_reg;
    logic [17:0]    block;
    rrw_pkg::addr_t addr_next;

    rrw_pkg::sq_t sq_pipe [rrw_pkg::SQ_STEPS+1];
    rrw_pkg::sq_t sq_next;
    rrw_pkg::dv_t dv_pipe [rrw_pkg::DIV_STEPS+1];

    assign adv          = !vld_reg[LAT-1] || result_ready;
    assign texel_ready  = adv;
    assign result_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frequency_reg <= rrw_pkg::FREQ_RESET;
            amplitude_reg <= rrw_pkg::AMP_RESET;
            phase_reg     <= rrw_pkg::PHASE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rrw_pkg::CFG_FREQUENCY: frequency_reg <= cfg_data;
                rrw_pkg::CFG_AMPLITUDE: amplitude_reg <= cfg_data;
                rrw_pkg::CFG_PHASE:     phase_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], texel_valid};
        end
    end

    // 4x4 tiles of 32 bytes, row-major inside a tile
    always_comb
    begin
        block     = 18'(TILES_PER_ROW * texel_row[4:2]) + 18'(texel_col[5:2]);
        addr_next = {block[6:0], 5'b0} + {7'b0, texel_row[1:0], 3'b0}
                  + {9'b0, texel_col[1:0], 1'b0};
    end

    always_comb
    begin
        sq_next      = '0;
        sq_next.rad  = rrw_pkg::rad_t'(sqx_reg) + rrw_pkg::rad_t'(sqy_reg);
        sq_next.dx   = dx_reg[1];
        sq_next.dy   = dy_reg[1];
        sq_next.addr = addr_reg[1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg[0]   <= dx_lut[texel_col];
            dy_reg[0]   <= dy_lut[texel_row];
            addr_reg[0] <= addr_next;
            dx_reg[1]   <= dx_reg[0];
            dy_reg[1]   <= dy_reg[0];
            addr_reg[1] <= addr_reg[0];
            sqx_reg     <= 38'(dx_reg[0] * dx_reg[0]);
            sqy_reg     <= 36'(dy_reg[0] * dy_reg[0]);
            sq_pipe[0]  <= sq_next;
        end
    end

    for (genvar k = 0; k < rrw_pkg::SQ_STEPS; k++)
    begin : g_sq
        rrw_sqrt_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .d_in  (sq_pipe[k]),
            .d_out (sq_pipe[k+1])
        );
    end

    // numerator is the position shifted up by 15; its top bits seed the remainder
    always_comb
    begin
        dv_pipe[0]      = '0;
        dv_pipe[0].d    = sq_pipe[rrw_pkg::SQ_STEPS].root;
        dv_pipe[0].remx = {3'b0, sq_pipe[rrw_pkg::SQ_STEPS].dx[18:1]};
        dv_pipe[0].numx = {sq_pipe[rrw_pkg::SQ_STEPS].dx[0], 15'b0};
        dv_pipe[0].remy = {4'b0, sq_pipe[rrw_pkg::SQ_STEPS].dy[17:1]};
        dv_pipe[0].numy = {sq_pipe[rrw_pkg::SQ_STEPS].dy[0], 15'b0};
        dv_pipe[0].addr = sq_pipe[rrw_pkg::SQ_STEPS].addr;
    end

    for (genvar k = 0; k < rrw_pkg::DIV_STEPS; k++)
    begin : g_dv
        rrw_div_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .d_in  (dv_pipe[k]),
            .d_out (dv_pipe[k+1])
        );
    end

    rrw_back u_back (
        .clk         (clk),
        .en          (adv),
        .d           (dv_pipe[rrw_pkg::DIV_STEPS].d),
        .ux          (dv_pipe[rrw_pkg::DIV_STEPS].qx),
        .uy          (dv_pipe[rrw_pkg::DIV_STEPS].qy),
        .addr        (dv_pipe[rrw_pkg::DIV_STEPS].addr),
        .frequency   (frequency_reg),
        .amplitude   (amplitude_reg),
        .phase_angle (phase_reg),
        .addr_out    (byte_address),
        .bx          (offset_x),
        .by          (offset_y)
    );

    // zero root only for the origin texel
    a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SQN] && (sq_pipe[rrw_pkg::SQ_STEPS].root == '0)
        |-> (sq_pipe[rrw_pkg::SQ_STEPS].dx == '0) && (sq_pipe[rrw_pkg::SQ_STEPS].dy == '0))
        else $error("root zero for nonzero position");

    // unit direction never exceeds one
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DVN] && (dv_pipe[rrw_pkg::DIV_STEPS].d != '0)
        |-> (dv_pipe[rrw_pkg::DIV_STEPS].qx <= 16'd32768)
            && (dv_pipe[rrw_pkg::DIV_STEPS].qy <= 16'd32768))
        else $error("direction quotient out of range");

    // a stall freezes the valid bits of every stage
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule
